// ===== rtl/cartridge_bank_mapper_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge bank mapper
// Shared concurrent assertion forms; all sample on clk and are off in reset.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_CORE_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Condition must hold at every clock edge outside reset.
`define CBM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent at one edge implies the consequent at the next edge.
`define CBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CBM_ASSERT_ALWAYS(lbl, cond, msg)
`define CBM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/cbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Field widths, access and region codes, mapper kinds and register map.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int ROM_ADDR_W = 21;
  localparam int RAM_ADDR_W = 15;
  localparam int ROM_BANK_W = 7;
  localparam int RAM_BANK_W = 2;
  localparam int KIND_W     = 2;
  localparam int REGION_W   = 2;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register byte addresses
  localparam logic [CFG_ADDR_W-1:0] REG_MAPPER_KIND = 2'd0;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Regions
  localparam logic [REGION_W-1:0] REGION_ROM_FIXED = 2'd0;
  localparam logic [REGION_W-1:0] REGION_ROM_BANK  = 2'd1;
  localparam logic [REGION_W-1:0] REGION_RAM       = 2'd2;
  localparam logic [REGION_W-1:0] REGION_OTHER     = 2'd3;

  // Mapper kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MBC1 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MBC2 = 2'd2;

  // Mapper register windows, selected by address bits 14:13 below 0x8000
  localparam logic [1:0] WIN_RAM_ENABLE = 2'd0;
  localparam logic [1:0] WIN_ROM_BANK   = 2'd1;
  localparam logic [1:0] WIN_UPPER      = 2'd2;
  localparam logic [1:0] WIN_MODE       = 2'd3;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

  localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 7'd1;

endpackage

// ===== rtl/cartridge_bank_mapper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank mapper core
// Classifies CPU bus accesses, translates ROM and RAM offsets and keeps the
// MBC1 / MBC2 style mapper registers.
// ----------------------------------------------------------------------------
//  Port group | Direction | Carries
//  in_*       | sink      | bus access: tuser = op, tdata = address, write_data
//  out_*      | source    | tuser = region, tdata = rom/ram address, write ok
//  cfg_*      | APB slave | mapper_kind at byte address 0
//
// One access per cycle while out_tready is high. An accepted access lands in
// the input register and moves to the result register, raising out_tvalid,
// once that register is empty or being read. Mapper registers are updated
// when an access leaves the input register, so the next access sees them.
// A stalled output holds its result while the input register still takes
// one more access. rst_n is synchronous and restores the reset state.
// ----------------------------------------------------------------------------
`include "cartridge_bank_mapper_core_assert.svh"

module cartridge_bank_mapper_core
  import cbm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // address[15:0], write_data[23:16]
  input  logic [0:0]             in_tuser,    // op[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // rom_address[20:0], ram_address[35:21],
                                              // ram_write_allowed[36], zero[39:37]
  output logic [REGION_W-1:0]    out_tuser,   // region[1:0]
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  // Configuration
  logic [KIND_W-1:0] kind_r;
  logic              cfg_wr;

  // Input register
  logic              s1_valid_r;
  logic              s1_op_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              s1_adv;

  // Mapper state
  logic [ROM_BANK_W-1:0] rom_bank_r, rom_bank_nxt;
  logic [RAM_BANK_W-1:0] ram_bank_r, ram_bank_nxt;
  logic                  ram_en_r, ram_en_nxt;
  logic                  mode_r, mode_nxt;

  // Result register
  logic                  out_valid_r;
  logic [REGION_W-1:0]   region_r, region_nxt;
  logic [ROM_ADDR_W-1:0] rom_addr_r, rom_addr_nxt;
  logic [RAM_ADDR_W-1:0] ram_addr_r, ram_addr_nxt;
  logic                  allowed_r, allowed_nxt;

  logic                  reg_write;
  logic                  m1, m2;
  logic [ROM_BANK_W-1:0] bank_tmp;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr == REG_MAPPER_KIND) ?
                      {{(CFG_DATA_W-KIND_W){1'b0}}, kind_r} : '0;

  assign s1_adv    = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | s1_adv;

  assign m1        = (kind_r == KIND_MBC1);
  assign m2        = (kind_r == KIND_MBC2);
  assign reg_write = (s1_op_r == OP_WRITE) && !s1_addr_r[15];

  // Translation of the access in the input register.
  always_comb begin
    region_nxt   = REGION_OTHER;
    rom_addr_nxt = '0;
    ram_addr_nxt = '0;
    allowed_nxt  = 1'b0;
    if (reg_write) begin
      region_nxt = REGION_OTHER;
    end else if (s1_addr_r[15:14] == 2'b00) begin
      region_nxt   = REGION_ROM_FIXED;
      rom_addr_nxt = {{(ROM_ADDR_W-14){1'b0}}, s1_addr_r[13:0]};
    end else if (s1_addr_r[15:14] == 2'b01) begin
      region_nxt   = REGION_ROM_BANK;
      rom_addr_nxt = {rom_bank_r, s1_addr_r[13:0]};
    end else if (s1_addr_r[15:13] == 3'b101) begin
      region_nxt   = REGION_RAM;
      ram_addr_nxt = {ram_bank_r, s1_addr_r[12:0]};
      allowed_nxt  = (s1_op_r == OP_WRITE) && ram_en_r;
    end
  end

  // Mapper register updates from writes below 0x8000.
  always_comb begin
    rom_bank_nxt = rom_bank_r;
    ram_bank_nxt = ram_bank_r;
    ram_en_nxt   = ram_en_r;
    mode_nxt     = mode_r;
    bank_tmp     = rom_bank_r;
    if (reg_write) begin
      unique case (s1_addr_r[14:13])
        WIN_RAM_ENABLE: begin
          if (m1 || (m2 && !s1_addr_r[8])) begin
            ram_en_nxt = (s1_data_r[3:0] == RAM_ENABLE_KEY);
          end
        end
        WIN_ROM_BANK: begin
          if (m1 || m2) begin
            if (m2) begin
              bank_tmp = {3'b000, s1_data_r[3:0]};
            end else begin
              bank_tmp = {rom_bank_r[6:5], s1_data_r[4:0]};
            end
            rom_bank_nxt = (bank_tmp == '0) ? ROM_BANK_RESET : bank_tmp;
          end
        end
        WIN_UPPER: begin
          if (m1) begin
            if (mode_r) begin
              bank_tmp     = {s1_data_r[1:0], rom_bank_r[4:0]};
              rom_bank_nxt = (bank_tmp == '0) ? ROM_BANK_RESET : bank_tmp;
            end else begin
              ram_bank_nxt = s1_data_r[1:0];
            end
          end
        end
        WIN_MODE: begin
          if (m1) begin
            mode_nxt = ~s1_data_r[0];
            if (!s1_data_r[0]) begin
              ram_bank_nxt = '0;
            end
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_MBC1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rom_bank_r  <= ROM_BANK_RESET;
      ram_bank_r  <= '0;
      ram_en_r    <= 1'b0;
      mode_r      <= 1'b1;
    end else begin
      if (cfg_wr) begin
        kind_r <= cfg_pwdata[KIND_W-1:0];
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        rom_bank_r  <= rom_bank_nxt;
        ram_bank_r  <= ram_bank_nxt;
        ram_en_r    <= ram_en_nxt;
        mode_r      <= mode_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser[0];
      s1_addr_r <= in_tdata[ADDR_W-1:0];
      s1_data_r <= in_tdata[ADDR_W+DATA_W-1:ADDR_W];
    end
    if (s1_adv) begin
      region_r   <= region_nxt;
      rom_addr_r <= rom_addr_nxt;
      ram_addr_r <= ram_addr_nxt;
      allowed_r  <= allowed_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = region_r;
  assign out_tdata  = {3'b000, allowed_r, ram_addr_r, rom_addr_r};

  `CBM_ASSERT_ALWAYS(a_rom_bank_nonzero, rom_bank_r != '0, "ROM bank register is zero")
  `CBM_ASSERT_ALWAYS(a_rom_mode_ram_bank, !mode_r || (ram_bank_r == '0),
                     "RAM bank nonzero in ROM banking mode")
  `CBM_ASSERT_ALWAYS(a_allowed_in_ram, !out_valid_r || !allowed_r || (region_r == REGION_RAM),
                     "RAM write allowed outside the RAM region")
  `CBM_ASSERT_ALWAYS(a_ram_addr_zero,
                     !out_valid_r || (region_r == REGION_RAM) || (ram_addr_r == '0),
                     "RAM offset set outside the RAM region")
  `CBM_ASSERT_NEXT(a_reg_write_other, s1_adv && reg_write,
                   out_valid_r && (region_r == REGION_OTHER) && (rom_addr_r == '0),
                   "Mapper register write did not report the other region")

endmodule
